// ----- rtl/nab_pkg.sv -----
// Shared types and constants for the neighbour average blur.
package nab_pkg;

	localparam int COL_W       = 11;
	localparam int ROW_W       = 12;
	localparam int CFG_W       = 12;
	localparam int CHAN_W      = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_WIDTH   = 2048;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pix_t;

	// One classified pixel on its way from the front to the back.
	typedef struct packed {
		pix_t             pix;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             border;
		logic             blur;
		logic             frame_last;
		logic             in_range;
	} item_t;

	typedef struct packed {
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		pix_t             pix;
		logic             run_end;
		logic             frame_end;
	} result_t;

endpackage

// ----- rtl/nab_front.sv -----
// Front end: frame size registers, position counters and pixel classification.
module nab_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  nab_pkg::cfg_reg_t          cfg_index,
	input  logic [nab_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [nab_pkg::CHAN_W-1:0] in_red,
	input  logic [nab_pkg::CHAN_W-1:0] in_green,
	input  logic [nab_pkg::CHAN_W-1:0] in_blue,
	input  logic                       q_full,
	output logic                       push,
	output nab_pkg::item_t             push_item
);
	import nab_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CFG_W-1:0] last_col_idx;
	logic [ROW_W-1:0] last_row_idx;
	logic [CFG_W-1:0] col_ext;
	logic             last_col;
	logic             last_row;

	always_comb begin
		// zero size acts as one, oversize width is clamped to the line buffer
		if (width_q == '0) begin
			last_col_idx = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			last_col_idx = CFG_W'(MAX_WIDTH - 1);
		end else begin
			last_col_idx = width_q - 1'b1;
		end
		if (height_q == '0) begin
			last_row_idx = '0;
		end else begin
			last_row_idx = ROW_W'(height_q - 1'b1);
		end
		col_ext  = CFG_W'(col_q);
		last_col = col_ext >= last_col_idx;
		last_row = row_q >= last_row_idx;

		push_item.pix.red   = in_red;
		push_item.pix.green = in_green;
		push_item.pix.blue  = in_blue;
		push_item.col        = col_q;
		push_item.row        = row_q;
		push_item.border     = (col_q == '0) || (row_q == '0) || last_col || last_row;
		push_item.blur       = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2)) &&
			(col_ext <= last_col_idx) && (row_q <= last_row_idx);
		push_item.frame_last = last_col && last_row;
		push_item.in_range   = 32'(col_q) < MAX_WIDTH;
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/nab_queue.sv -----
// Small flop FIFO of classified pixels between the front and the back.
module nab_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nab_pkg::item_t push_item,
	output logic           full,
	output logic           pop_valid,
	input  logic           pop,
	output nab_pkg::item_t pop_item
);
	import nab_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full      = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/nab_back.sv -----
// Back end: line buffers, 3x3 window, neighbour sum and result register.
module nab_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop,
	input  nab_pkg::item_t   pop_item,
	output logic             out_valid,
	input  logic             out_stall,
	output nab_pkg::result_t out_result
);
	import nab_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	pix_t            older_mem [MAX_WIDTH];
	pix_t            newer_mem [MAX_WIDTH];

	logic            valid_s1;
	item_t           item_s1;
	pix_t            older_s1;
	pix_t            newer_s1;
	logic            fwd_s1;
	pix_t            fwd_older_s1;
	pix_t            fwd_newer_s1;
	logic            second_q;
	pix_t            window_q [6];
	logic            res_valid_q;
	result_t         res_q;

	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	pix_t            above2;
	pix_t            above1;
	pix_t            nb [8];
	pix_t            blur_pix;
	logic [CHAN_W-1:0] sum_r;
	logic [CHAN_W-1:0] sum_g;
	logic [CHAN_W-1:0] sum_b;
	logic            out_load;
	logic            has_res;
	logic            emit_blur;
	logic            emit;
	logic            done;
	logic            fwd_hit;
	result_t         res_next;

	assign rd_addr = AW'(pop_item.col);
	assign wr_addr = AW'(item_s1.col);

	always_comb begin
		if (!item_s1.in_range) begin
			above2 = '0;
			above1 = '0;
		end else if (fwd_s1) begin
			above2 = fwd_older_s1;
			above1 = fwd_newer_s1;
		end else begin
			above2 = older_s1;
			above1 = newer_s1;
		end

		nb[0] = window_q[0];
		nb[1] = window_q[1];
		nb[2] = above2;
		nb[3] = window_q[2];
		nb[4] = above1;
		nb[5] = window_q[4];
		nb[6] = window_q[5];
		nb[7] = item_s1.pix;

		// eight terms of at most 31 each, so the 8-bit sum never wraps
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int i = 0; i < 8; i++) begin
			sum_r = sum_r + (nb[i].red >> 3);
			sum_g = sum_g + (nb[i].green >> 3);
			sum_b = sum_b + (nb[i].blue >> 3);
		end
		blur_pix.red   = sum_r;
		blur_pix.green = sum_g;
		blur_pix.blue  = sum_b;

		out_load  = !res_valid_q || !out_stall;
		has_res   = item_s1.blur || item_s1.border;
		emit_blur = item_s1.blur && !second_q;
		emit      = valid_s1 && has_res && out_load;
		done      = valid_s1 && (!has_res || (out_load && !(emit_blur && item_s1.border)));
		pop       = pop_valid && (!valid_s1 || done);
		// same column written and read at one edge: take the write data
		fwd_hit   = valid_s1 && done && item_s1.in_range && (rd_addr == wr_addr);

		if (emit_blur) begin
			res_next.x         = item_s1.col - 1'b1;
			res_next.y         = item_s1.row - 1'b1;
			res_next.pix       = blur_pix;
			res_next.run_end   = !item_s1.border;
			res_next.frame_end = 1'b0;
		end else begin
			res_next.x         = item_s1.col;
			res_next.y         = item_s1.row;
			res_next.pix       = item_s1.pix;
			res_next.run_end   = 1'b1;
			res_next.frame_end = item_s1.frame_last;
		end
	end

	always_ff @(posedge clk) begin
		if (done && item_s1.in_range) begin
			older_mem[wr_addr] <= above1;
		end
		if (pop) begin
			older_s1 <= older_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (done && item_s1.in_range) begin
			newer_mem[wr_addr] <= item_s1.pix;
		end
		if (pop) begin
			newer_s1 <= newer_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1      <= pop_item;
			fwd_s1       <= fwd_hit;
			fwd_older_s1 <= above1;
			fwd_newer_s1 <= item_s1.pix;
		end
		if (emit) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			second_q    <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				window_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				second_q <= 1'b0;
			end else if (emit && emit_blur) begin
				second_q <= 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
			if (done) begin
				window_q[0] <= window_q[1];
				window_q[1] <= above2;
				window_q[2] <= window_q[3];
				window_q[3] <= above1;
				window_q[4] <= window_q[5];
				window_q[5] <= item_s1.pix;
			end
		end
	end

	assign out_valid  = res_valid_q;
	assign out_result = res_q;

endmodule

// ----- rtl/neighbour_average_blur.sv -----
// Top level of the streaming 3x3 neighbour average blur.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  cfg     | in        | cfg_write           | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall | in_red, in_green, in_blue
//  out     | out       | out_valid/out_stall | out_x, out_y, out_red, out_green,
//          |           |                     | out_blue, run_end, frame_end
//
// One pixel per clock while the output is not stalled and each pixel yields at most one
// result; a pixel that yields two results (blurred pixel plus border pixel) loads the
// single output register twice before the next pixel is taken.
// Reset sets width 640, height 480 and clears counters and window; line buffers are
// not cleared. Output stall backs up through the back stage into a four-entry queue,
// and in_stall rises only when that queue is full.
module neighbour_average_blur (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  nab_pkg::cfg_reg_t          cfg_index,
	input  logic [nab_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [nab_pkg::CHAN_W-1:0] in_red,
	input  logic [nab_pkg::CHAN_W-1:0] in_green,
	input  logic [nab_pkg::CHAN_W-1:0] in_blue,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [nab_pkg::COL_W-1:0]  out_x,
	output logic [nab_pkg::ROW_W-1:0]  out_y,
	output logic [nab_pkg::CHAN_W-1:0] out_red,
	output logic [nab_pkg::CHAN_W-1:0] out_green,
	output logic [nab_pkg::CHAN_W-1:0] out_blue,
	output logic                       run_end,
	output logic                       frame_end
);
	import nab_pkg::*;

	logic    push;
	item_t   push_item;
	logic    q_full;
	logic    pop_valid;
	logic    pop;
	item_t   pop_item;
	result_t result;

	nab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	nab_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	nab_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_result (result)
	);

	assign out_x     = result.x;
	assign out_y     = result.y;
	assign out_red   = result.pix.red;
	assign out_green = result.pix.green;
	assign out_blue  = result.pix.blue;
	assign run_end   = result.run_end;
	assign frame_end = result.frame_end;

endmodule
